@@ sv/assert_macros.svh @@
// Assertion macros shared by the depth normal and back-projection RTL.
// Included by the top-level module, which carries the concurrent checks; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset
`define DNB_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("dnb assertion failed");

// Next-cycle implication, disabled during reset
`define DNB_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("dnb assertion failed");

`endif

@@ sv/dnb_pkg.sv @@
// Package for the depth normal and back-projection block: register codes,
// reset values and fixed field widths. No dependencies.
`default_nettype none
package dnb_pkg;

   // Register map, one index per 32-bit word
   typedef enum logic [2:0] {
      CFG_MIN_DEPTH     = 3'd0,
      CFG_MAX_DEPTH     = 3'd1,
      CFG_LAST_COLUMN   = 3'd2,
      CFG_LAST_ROW      = 3'd3,
      CFG_RECIP_FOCAL_X = 3'd4,
      CFG_CENTER_X      = 3'd5,
      CFG_RECIP_FOCAL_Y = 3'd6,
      CFG_CENTER_Y      = 3'd7
   } cfg_index_type;

   localparam int ADDR_W       = 5;
   localparam int CSR_DATA_W   = 32;
   localparam int INDEX_W      = 13;
   localparam int REQ_DATA_W   = 112;
   localparam int RSP_DATA_W   = 112;
   localparam int VERTEX_W     = 21;
   localparam int VZ_W         = 17;
   localparam int RECIP_W      = 26;
   localparam int CENTER_W     = 24;
   localparam int NEIGHBOR_LIMIT = 20;

   localparam logic [15:0] RST_MIN_DEPTH     = 16'd0;
   localparam logic [15:0] RST_MAX_DEPTH     = 16'd65535;
   localparam logic [12:0] RST_LAST_COLUMN   = 13'd639;
   localparam logic [12:0] RST_LAST_ROW      = 13'd479;
   localparam logic [25:0] RST_RECIP_FOCAL_X = 26'd7497114;
   localparam logic [23:0] RST_CENTER_X      = 24'd80550;
   localparam logic [25:0] RST_RECIP_FOCAL_Y = 26'd7913490;
   localparam logic [23:0] RST_CENTER_Y      = 24'd61481;

endpackage
`default_nettype wire

@@ sv/dnb_delay.sv @@
// Enable-gated shift line that carries side data alongside the pipeline.
// Generic; no package dependencies.
`default_nettype none
module dnb_delay #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             en,
   input  logic [WIDTH-1:0] din,
   output logic [WIDTH-1:0] dout
);
   logic [WIDTH-1:0] line_ff [DEPTH];

   // Advance every tap together when the pipeline moves
   for (genvar i = 0; i < DEPTH; i++) begin : g_tap
      if (i == 0) begin : g_first
         always_ff @(posedge clock) begin
            if (en) line_ff[i] <= din;
         end
      end else begin : g_next
         always_ff @(posedge clock) begin
            if (en) line_ff[i] <= line_ff[i-1];
         end
      end
   end

   assign dout = line_ff[DEPTH-1];
endmodule
`default_nettype wire

@@ sv/dnb_sqrt.sv @@
// Pipelined integer square root, one result bit per register stage.
// Generic; no package dependencies.
`default_nettype none
module dnb_sqrt #(
   parameter int SW = 50,
   parameter int RW = 25
) (
   input  logic          clock,
   input  logic          en,
   input  logic [SW-1:0] din,
   output logic [RW-1:0] root
);
   logic [SW-1:0] v_ff [RW];
   logic [SW-1:0] r_ff [RW];

   for (genvar j = 0; j < RW; j++) begin : g_step
      localparam logic [SW-1:0] BIT = {{(SW-1){1'b0}}, 1'b1} << (2 * (RW - 1 - j));
      logic [SW-1:0] v_pre, r_pre, v_in, r_in, trial;

      if (j == 0) begin : g_first
         assign v_pre = din;
         assign r_pre = '0;
      end else begin : g_next
         assign v_pre = v_ff[j-1];
         assign r_pre = r_ff[j-1];
      end

      // Try the next root bit and keep it when the remainder allows
      always_comb begin
         trial = r_pre + BIT;
         if (v_pre >= trial) begin
            v_in = v_pre - trial;
            r_in = (r_pre >> 1) + BIT;
         end else begin
            v_in = v_pre;
            r_in = r_pre >> 1;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            v_ff[j] <= v_in;
            r_ff[j] <= r_in;
         end
      end
   end

   assign root = r_ff[RW-1][RW-1:0];
endmodule
`default_nettype wire

@@ sv/dnb_div.sv @@
// Pipelined restoring divider, one quotient bit per register stage.
// Generic; no package dependencies.
`default_nettype none
module dnb_div #(
   parameter int NW = 50,
   parameter int DW = 26,
   parameter int QB = 17
) (
   input  logic          clock,
   input  logic          en,
   input  logic [NW-1:0] num,
   input  logic [DW-1:0] den,
   output logic [QB-1:0] quo
);
   logic [NW-1:0] rem_ff [QB];
   logic [DW-1:0] den_ff [QB];
   logic [QB-1:0] q_ff   [QB];

   for (genvar s = 0; s < QB; s++) begin : g_step
      localparam int K = QB - 1 - s;
      logic [NW-1:0] rem_pre, rem_in, trial;
      logic [DW-1:0] den_pre;
      logic [QB-1:0] q_pre, q_in;

      if (s == 0) begin : g_first
         assign rem_pre = num;
         assign den_pre = den;
         assign q_pre   = '0;
      end else begin : g_next
         assign rem_pre = rem_ff[s-1];
         assign den_pre = den_ff[s-1];
         assign q_pre   = q_ff[s-1];
      end

      // Subtract the shifted divisor when it fits and set this quotient bit
      always_comb begin
         trial = {{(NW-DW){1'b0}}, den_pre} << K;
         q_in  = q_pre;
         if (rem_pre >= trial) begin
            rem_in  = rem_pre - trial;
            q_in[K] = 1'b1;
         end else begin
            rem_in = rem_pre;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[s] <= rem_in;
            den_ff[s] <= den_pre;
            q_ff[s]   <= q_in;
         end
      end
   end

   assign quo = q_ff[QB-1];
endmodule
`default_nettype wire

@@ sv/depth_normal_and_backprojection.sv @@
// Depth pixel to surface normal and back-projected vertex, top level.
// Depends on dnb_pkg, dnb_sqrt, dnb_div, dnb_delay and assert_macros.svh.
//
// Usage: one pixel per req_ transaction (center depth, four neighbors, row,
// column); one rsp_ transaction per pixel carries the Q1.F normal, the vertex
// in 1/16 mm and the valid flag in rsp_tuser. Results come out in order.
// A pixel passes 17 + DEPTH_BITS + NORMAL_FRAC_BITS registers: six single
// stages (capture, gating, products, length, divider operands, output), one
// square-root stage per root bit (DEPTH_BITS + 9) and one divider stage per
// quotient bit (NORMAL_FRAC_BITS + 2). The accepting edge loads the first,
// and rsp_tvalid rises once the pixel reaches the output register.
// Throughput is one pixel per clock while no stall holds the pipeline.
// The pipeline advances as a whole whenever the output register is empty or
// being taken; while rsp_tready is low with a result waiting, every stage holds
// and req_tready drops, and nothing is lost or repeated. Bubbles travel as
// cleared valid bits. Synchronous reset empties the pipeline and loads the
// register defaults (640x480 intrinsics, full depth band). pready is always
// high. Write the csr_ port only while the block is idle (not enforced).
`default_nettype none
module depth_normal_and_backprojection
   import dnb_pkg::*;
#(
   parameter int DEPTH_BITS       = 16,
   parameter int NORMAL_FRAC_BITS = 15
) (
   input  logic                  clock,
   input  logic                  reset,
   // center_depth[15:0] next_row_depth[31:16] prev_row_depth[47:32]
   // next_col_depth[63:48] prev_col_depth[79:64] row_index[92:80]
   // col_index[105:93], zero fill above
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // normal_first[15:0] normal_second[31:16] normal_third[47:32]
   // vertex_x[68:48] vertex_y[89:69] vertex_z[106:90], zero fill above
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   // vertex_valid[0]
   output logic [0:0]            rsp_tuser,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [ADDR_W-1:0]     csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);
`include "assert_macros.svh"

   localparam int DB   = DEPTH_BITS;
   localparam int F    = NORMAL_FRAC_BITS;
   localparam int L2W  = 2 * DB + 2;
   localparam int SW   = L2W + 16;
   localparam int RW   = SW / 2;
   localparam int NW   = DB + F + 11;
   localparam int DNW  = RW + 1;
   localparam int QB   = F + 2;
   localparam int T    = 6 + RW + QB;
   localparam int PW   = DB + 27;
   localparam int MW   = DB + 24;
   localparam int SUMW = MW + 27;
   localparam int QW   = SUMW - 36;
   localparam int AUXW = 2 + 1 + VZ_W;
   localparam int N3_MAX = (F >= 16) ? 65535 : (1 << F);
   localparam int LIM_P  = (1 << F) - 1;
   localparam int LIM_N  = 1 << F;

   // Configuration registers
   logic [15:0]         min_depth_ff, max_depth_ff;
   logic [12:0]         last_column_ff, last_row_ff;
   logic [RECIP_W-1:0]  recip_focal_x_ff, recip_focal_y_ff;
   logic [CENTER_W-1:0] center_x_ff, center_y_ff;
   cfg_index_type       csr_index;
   logic                csr_write;

   assign csr_pready = 1'b1;
   assign csr_index  = cfg_index_type'(csr_paddr[4:2]);
   assign csr_write  = csr_psel & csr_penable & csr_pwrite;

   // Write the addressed register
   always_ff @(posedge clock) begin
      if (reset) begin
         min_depth_ff     <= RST_MIN_DEPTH;
         max_depth_ff     <= RST_MAX_DEPTH;
         last_column_ff   <= RST_LAST_COLUMN;
         last_row_ff      <= RST_LAST_ROW;
         recip_focal_x_ff <= RST_RECIP_FOCAL_X;
         center_x_ff      <= RST_CENTER_X;
         recip_focal_y_ff <= RST_RECIP_FOCAL_Y;
         center_y_ff      <= RST_CENTER_Y;
      end else if (csr_write) begin
         case (csr_index)
            CFG_MIN_DEPTH:     min_depth_ff     <= csr_pwdata[15:0];
            CFG_MAX_DEPTH:     max_depth_ff     <= csr_pwdata[15:0];
            CFG_LAST_COLUMN:   last_column_ff   <= csr_pwdata[12:0];
            CFG_LAST_ROW:      last_row_ff      <= csr_pwdata[12:0];
            CFG_RECIP_FOCAL_X: recip_focal_x_ff <= csr_pwdata[RECIP_W-1:0];
            CFG_CENTER_X:      center_x_ff      <= csr_pwdata[CENTER_W-1:0];
            CFG_RECIP_FOCAL_Y: recip_focal_y_ff <= csr_pwdata[RECIP_W-1:0];
            CFG_CENTER_Y:      center_y_ff      <= csr_pwdata[CENTER_W-1:0];
            default: ;
         endcase
      end
   end

   // Read back the addressed register
   always_comb begin
      case (csr_index)
         CFG_MIN_DEPTH:     csr_prdata = {16'b0, min_depth_ff};
         CFG_MAX_DEPTH:     csr_prdata = {16'b0, max_depth_ff};
         CFG_LAST_COLUMN:   csr_prdata = {19'b0, last_column_ff};
         CFG_LAST_ROW:      csr_prdata = {19'b0, last_row_ff};
         CFG_RECIP_FOCAL_X: csr_prdata = {6'b0, recip_focal_x_ff};
         CFG_CENTER_X:      csr_prdata = {8'b0, center_x_ff};
         CFG_RECIP_FOCAL_Y: csr_prdata = {6'b0, recip_focal_y_ff};
         CFG_CENTER_Y:      csr_prdata = {8'b0, center_y_ff};
         default:           csr_prdata = '0;
      endcase
   end

   // Pipeline control: move everything when the output is free or taken
   logic         en;
   logic [T-1:0] vld_ff;

   assign en         = rsp_tready | ~vld_ff[T-1];
   assign req_tready = en;
   assign rsp_tvalid = vld_ff[T-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[T-2:0], req_tvalid};
      end
   end

   // Stage 0: capture the transaction
   logic [DB-1:0]      z0_ff, nr0_ff, pr0_ff, nc0_ff, pc0_ff;
   logic [INDEX_W-1:0] row0_ff, col0_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         z0_ff   <= req_tdata[DB-1:0];
         nr0_ff  <= req_tdata[16+DB-1:16];
         pr0_ff  <= req_tdata[32+DB-1:32];
         nc0_ff  <= req_tdata[48+DB-1:48];
         pc0_ff  <= req_tdata[64+DB-1:64];
         row0_ff <= req_tdata[92:80];
         col0_ff <= req_tdata[105:93];
      end
   end

   // Drop a neighbor that strays too far from the center
   function automatic logic [DB-1:0] gate_fn(input logic [DB-1:0] c, input logic [DB-1:0] n);
      logic signed [DB:0] diff;
      logic [DB:0]        mag;
      diff = $signed({1'b0, c}) - $signed({1'b0, n});
      mag  = diff[DB] ? -diff : diff;
      return (mag > (DB+1)'(NEIGHBOR_LIMIT)) ? '0 : n;
   endfunction

   // Stage 1: border test, gating and gradients; vertex offsets
   logic                border;
   logic [DB-1:0]       nr_g, pr_g, nc_g, pc_g;
   logic signed [DB:0]  d1_ff, d2_ff;
   logic [DB-1:0]       z1_ff;
   logic signed [25:0]  xd1_ff, yd1_ff;

   always_comb begin
      border = (row0_ff == '0) || (col0_ff == '0) ||
               (row0_ff >= last_row_ff) || (col0_ff >= last_column_ff);
      nr_g = gate_fn(z0_ff, border ? '0 : nr0_ff);
      pr_g = gate_fn(z0_ff, border ? '0 : pr0_ff);
      nc_g = gate_fn(z0_ff, border ? '0 : nc0_ff);
      pc_g = gate_fn(z0_ff, border ? '0 : pc0_ff);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         d1_ff  <= $signed({1'b0, nr_g}) - $signed({1'b0, pr_g});
         d2_ff  <= $signed({1'b0, nc_g}) - $signed({1'b0, pc_g});
         z1_ff  <= z0_ff;
         xd1_ff <= $signed({5'b0, col0_ff, 8'b0}) - $signed({2'b0, center_x_ff});
         yd1_ff <= $signed({2'b0, center_y_ff}) - $signed({5'b0, row0_ff, 8'b0});
      end
   end

   // Stage 2: gradient magnitudes and squares; vertex products; side flags
   logic [DB:0]         m1, m2;
   logic [DB-1:0]       mag1_ff, mag2_ff;
   logic [2*DB-1:0]     sq1_ff, sq2_ff;
   logic signed [PW-1:0] px2_ff, py2_ff;
   logic [AUXW-1:0]     aux2_ff;
   logic [15:0]         z16;
   logic                valid1;

   always_comb begin
      m1     = d1_ff[DB] ? -d1_ff : d1_ff;
      m2     = d2_ff[DB] ? -d2_ff : d2_ff;
      z16    = 16'(z1_ff);
      valid1 = (z16 != '0) && (z16 >= min_depth_ff) && (z16 <= max_depth_ff);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         mag1_ff <= m1[DB-1:0];
         mag2_ff <= m2[DB-1:0];
         sq1_ff  <= m1[DB-1:0] * m1[DB-1:0];
         sq2_ff  <= m2[DB-1:0] * m2[DB-1:0];
         px2_ff  <= PW'($signed({1'b0, z1_ff})) * PW'(xd1_ff);
         py2_ff  <= PW'($signed({1'b0, z1_ff})) * PW'(yd1_ff);
         // Normal component is negative where the gradient is positive
         aux2_ff <= {(~d1_ff[DB] && d1_ff != '0), (~d2_ff[DB] && d2_ff != '0), valid1,
                     VZ_W'(0) - VZ_W'(z1_ff)};
      end
   end

   // Stage 3: squared length with sixteen fraction bits, so the root has eight
   logic [SW-1:0] s3_ff;

   always_ff @(posedge clock) begin
      if (en) s3_ff <= {L2W'(sq1_ff) + L2W'(sq2_ff) + L2W'(4), 16'b0};
   end

   logic [RW-1:0] len8;

   dnb_sqrt #(.SW(SW), .RW(RW)) u_sqrt (
      .clock (clock),
      .en    (en),
      .din   (s3_ff),
      .root  (len8)
   );

   // Carry the gradient magnitudes up to the divider inputs
   logic [DB-1:0] mag1_d, mag2_d;

   dnb_delay #(.WIDTH(2 * DB), .DEPTH(RW + 1)) u_mag_dly (
      .clock (clock),
      .en    (en),
      .din   ({mag1_ff, mag2_ff}),
      .dout  ({mag1_d, mag2_d})
   );

   // Divider operands: rounded quotient of magnitude over length
   logic [NW-1:0]  num1_ff, num2_ff, num3_ff;
   logic [DNW-1:0] den_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         num1_ff <= (NW'(mag1_d) << (F + 9)) + NW'(len8);
         num2_ff <= (NW'(mag2_d) << (F + 9)) + NW'(len8);
         num3_ff <= (NW'(2) << (F + 9)) + NW'(len8);
         den_ff  <= {len8, 1'b0};
      end
   end

   logic [QB-1:0] q1, q2, q3;

   dnb_div #(.NW(NW), .DW(DNW), .QB(QB)) u_div1 (
      .clock (clock), .en (en), .num (num1_ff), .den (den_ff), .quo (q1)
   );
   dnb_div #(.NW(NW), .DW(DNW), .QB(QB)) u_div2 (
      .clock (clock), .en (en), .num (num2_ff), .den (den_ff), .quo (q2)
   );
   dnb_div #(.NW(NW), .DW(DNW), .QB(QB)) u_div3 (
      .clock (clock), .en (en), .num (num3_ff), .den (den_ff), .quo (q3)
   );

   // Vertex stage 3: split sign and magnitude
   logic [MW-1:0] mx3_ff, my3_ff;
   logic          sx3_ff, sy3_ff;
   logic signed [PW-1:0] ax, ay;

   always_comb begin
      ax = px2_ff[PW-1] ? -px2_ff : px2_ff;
      ay = py2_ff[PW-1] ? -py2_ff : py2_ff;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         mx3_ff <= ax[MW-1:0];
         my3_ff <= ay[MW-1:0];
         sx3_ff <= px2_ff[PW-1];
         sy3_ff <= py2_ff[PW-1];
      end
   end

   // Vertex stage 4: partial products with the reciprocal focal lengths
   logic [MW+12:0] ax4_ff, bx4_ff, ay4_ff, by4_ff;
   logic           sx4_ff, sy4_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         ax4_ff <= mx3_ff * recip_focal_x_ff[25:13];
         bx4_ff <= mx3_ff * recip_focal_x_ff[12:0];
         ay4_ff <= my3_ff * recip_focal_y_ff[25:13];
         by4_ff <= my3_ff * recip_focal_y_ff[12:0];
         sx4_ff <= sx3_ff;
         sy4_ff <= sy3_ff;
      end
   end

   // Vertex stage 5: combine and round half up to 1/16 mm
   logic [SUMW-1:0] sumx, sumy;
   logic [QW-1:0]   qx5_ff, qy5_ff;
   logic            sx5_ff, sy5_ff;

   always_comb begin
      sumx = {1'b0, ax4_ff, 13'b0} + SUMW'(bx4_ff) + (SUMW'(1) << 35);
      sumy = {1'b0, ay4_ff, 13'b0} + SUMW'(by4_ff) + (SUMW'(1) << 35);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         qx5_ff <= sumx[SUMW-1:36];
         qy5_ff <= sumy[SUMW-1:36];
         sx5_ff <= sx4_ff;
         sy5_ff <= sy4_ff;
      end
   end

   // Apply the sign and saturate to the vertex range
   function automatic logic [VERTEX_W-1:0] sat_vertex(input logic [QW-1:0] q, input logic neg);
      logic [VERTEX_W-1:0] r;
      if (neg) begin
         r = (q > QW'(1048576)) ? VERTEX_W'(1048576) : (VERTEX_W'(0) - q[VERTEX_W-1:0]);
      end else begin
         r = (q > QW'(1048575)) ? VERTEX_W'(1048575) : q[VERTEX_W-1:0];
      end
      return r;
   endfunction

   logic [VERTEX_W-1:0] vx6_ff, vy6_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         vx6_ff <= sat_vertex(qx5_ff, sx5_ff);
         vy6_ff <= sat_vertex(qy5_ff, sy5_ff);
      end
   end

   // Align vertex and side flags with the divider outputs
   logic [VERTEX_W-1:0] vx_d, vy_d;
   logic [AUXW-1:0]     aux_d;

   dnb_delay #(.WIDTH(2 * VERTEX_W), .DEPTH(T - 8)) u_vtx_dly (
      .clock (clock),
      .en    (en),
      .din   ({vx6_ff, vy6_ff}),
      .dout  ({vx_d, vy_d})
   );

   dnb_delay #(.WIDTH(AUXW), .DEPTH(T - 4)) u_aux_dly (
      .clock (clock),
      .en    (en),
      .din   (aux2_ff),
      .dout  (aux_d)
   );

   // Clamp a normal component to the Q1.F range, then to 16 bits
   function automatic logic [15:0] sat_normal(input logic [QB-1:0] q, input logic neg);
      logic signed [31:0] qv, r;
      qv = 32'(q);
      if (neg) r = -((qv > LIM_N) ? 32'(LIM_N) : qv);
      else     r = (qv > LIM_P) ? 32'(LIM_P) : qv;
      if (r > 32767)       r = 32'sd32767;
      else if (r < -32768) r = -32'sd32768;
      return r[15:0];
   endfunction

   // Output register
   logic [15:0]         out_n1_ff, out_n2_ff, out_n3_ff;
   logic [VERTEX_W-1:0] out_vx_ff, out_vy_ff;
   logic [VZ_W-1:0]     out_vz_ff;
   logic                out_valid_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         out_n1_ff    <= sat_normal(q1, aux_d[AUXW-1]);
         out_n2_ff    <= sat_normal(q2, aux_d[AUXW-2]);
         out_n3_ff    <= (32'(q3) > 65535) ? 16'hFFFF : 16'(q3);
         out_vx_ff    <= vx_d;
         out_vy_ff    <= vy_d;
         out_vz_ff    <= aux_d[VZ_W-1:0];
         out_valid_ff <= aux_d[VZ_W];
      end
   end

   assign rsp_tdata = {5'b0, out_vz_ff, out_vy_ff, out_vx_ff, out_n3_ff, out_n2_ff, out_n1_ff};
   assign rsp_tuser = out_valid_ff;

   // A valid vertex never has zero depth
   `DNB_ASSERT_IMP(a_valid_depth, clock, reset, rsp_tvalid && out_valid_ff, out_vz_ff != '0)
   // The z component of the normal stays within one in Q1.F
   `DNB_ASSERT_IMP(a_n3_range, clock, reset, rsp_tvalid, 32'(out_n3_ff) <= N3_MAX)
   // A stall freezes the occupancy of every stage
   `DNB_ASSERT_NXT(a_stall_hold, clock, reset, !en, $stable(vld_ff))

endmodule
`default_nettype wire

@@ sim/depth_normal_and_backprojection_tb.sv @@
// Self-checking testbench for depth_normal_and_backprojection: drives pixel
// transactions, predicts normals and vertices, and compares every result.
// Depends on dnb_pkg and the depth_normal_and_backprojection RTL.
`default_nettype none
module depth_normal_and_backprojection_tb
   import dnb_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      logic [15:0] center, next_row, prev_row, next_col, prev_col;
      logic [12:0] row, col;
   } pixel_type;

   typedef struct {
      logic [15:0] nrm_first, nrm_second, nrm_third;
      logic [20:0] vx, vy;
      logic [16:0] vz;
      logic        valid;
   } point_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic [0:0] rsp_tuser;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic csr_psel = 1'b0, csr_penable = 1'b0, csr_pwrite = 1'b0;
   logic [ADDR_W-1:0] csr_paddr = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic csr_pready;

   // Shadow copy of the register file
   logic [15:0] min_depth_q, max_depth_q;
   logic [12:0] last_col_q, last_row_q;
   logic [25:0] rfx_q, rfy_q;
   logic [23:0] cx_q, cy_q;

   point_type expected_points[$];
   int     error_count = 0;
   bit     calm = 1'b0;
   int     quiet_cycles = 0;

   depth_normal_and_backprojection uut (
      .clock(clock), .reset(reset),
      .req_tdata(req_tdata), .req_tvalid(req_tvalid), .req_tready(req_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser), .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Prediction
   function automatic longint unsigned int_sqrt(longint unsigned v);
      longint unsigned res = 0;
      longint unsigned bitv = 64'd1 << 62;
      while (bitv > v) bitv = bitv >> 2;
      while (bitv != 0) begin
         if (v >= res + bitv) begin
            v = v - (res + bitv);
            res = (res >> 1) + bitv;
         end else begin
            res = res >> 1;
         end
         bitv = bitv >> 2;
      end
      return res;
   endfunction

   function automatic longint scaled_component(longint num, longint unsigned len8);
      longint unsigned mag = longint'(num < 0 ? -num : num) << 23;
      longint unsigned q = (2 * mag + len8) / (2 * len8);
      return num < 0 ? -longint'(q) : longint'(q);
   endfunction

   function automatic longint clamp(longint v, longint lo, longint hi);
      return v < lo ? lo : (v > hi ? hi : v);
   endfunction

   function automatic longint project_axis(longint p, logic [25:0] recip);
      logic [95:0] m = 96'(p < 0 ? -p : p);
      logic [95:0] prod = m * 96'(recip) + (96'd1 << 35);
      longint s = longint'(prod >> 36);
      return clamp(p < 0 ? -s : s, -1048576, 1048575);
   endfunction

   function automatic longint unsigned gated(longint c, longint unsigned n);
      longint d = c - longint'(n);
      if (d < 0) d = -d;
      return d > NEIGHBOR_LIMIT ? 0 : n;
   endfunction

   function automatic point_type predict_point(pixel_type px);
      point_type o;
      longint c = longint'(px.center);
      longint unsigned nr = 0, pr = 0, nc = 0, pc = 0, len8;
      longint d1, d2, n1, n2, n3, pxv, pyv;
      if (px.row > 0 && px.col > 0 && px.row < last_row_q && px.col < last_col_q) begin
         nr = px.next_row; pr = px.prev_row; nc = px.next_col; pc = px.prev_col;
      end
      nr = gated(c, nr); pr = gated(c, pr); nc = gated(c, nc); pc = gated(c, pc);
      d1 = longint'(nr) - longint'(pr);
      d2 = longint'(nc) - longint'(pc);
      len8 = int_sqrt(longint'(d1 * d1 + d2 * d2 + 4) << 16);
      n1 = clamp(scaled_component(-d1, len8), -32768, 32767);
      n2 = clamp(scaled_component(-d2, len8), -32768, 32767);
      n3 = clamp(scaled_component(2, len8), 0, 65535);
      pxv = c * ((longint'(px.col) << 8) - longint'(cx_q));
      pyv = c * ((longint'(px.row) << 8) - longint'(cy_q));
      o.nrm_first = n1[15:0];
      o.nrm_second = n2[15:0];
      o.nrm_third = n3[15:0];
      o.vx = 21'(project_axis(pxv, rfx_q));
      o.vy = 21'(project_axis(-pyv, rfy_q));
      o.vz = 17'(-c);
      o.valid = px.center != 0 && px.center >= min_depth_q && px.center <= max_depth_q;
      return o;
   endfunction

   // Result checking
   task automatic report_mismatch(string what, longint got, longint want);
      $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
      error_count++;
   endtask

   always @(posedge clock) begin
      point_type w;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_points.size() == 0) begin
            report_mismatch("unexpected result", longint'(rsp_tdata[63:0]), longint'(0));
         end else begin
            w = expected_points.pop_front();
            if (rsp_tdata[15:0] != w.nrm_first)
               report_mismatch("normal_first", longint'(rsp_tdata[15:0]),
                               longint'(w.nrm_first));
            if (rsp_tdata[31:16] != w.nrm_second)
               report_mismatch("normal_second", longint'(rsp_tdata[31:16]),
                               longint'(w.nrm_second));
            if (rsp_tdata[47:32] != w.nrm_third)
               report_mismatch("normal_third", longint'(rsp_tdata[47:32]),
                               longint'(w.nrm_third));
            if (rsp_tdata[68:48] != w.vx)
               report_mismatch("vertex_x", longint'(rsp_tdata[68:48]), longint'(w.vx));
            if (rsp_tdata[89:69] != w.vy)
               report_mismatch("vertex_y", longint'(rsp_tdata[89:69]), longint'(w.vy));
            if (rsp_tdata[106:90] != w.vz)
               report_mismatch("vertex_z", longint'(rsp_tdata[106:90]), longint'(w.vz));
            if (rsp_tuser[0] != w.valid)
               report_mismatch("vertex_valid", longint'(rsp_tuser[0]), longint'(w.valid));
         end
      end
   end

   // Receiver back-pressure in random bursts
   always @(posedge clock) begin
      int stall;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (stall > 0) begin
         stall--;
         rsp_tready <= 1'b0;
      end else if (!calm && $urandom_range(0, 9) == 0) begin
         stall = $urandom_range(1, 14) - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // Watchdog on cycles without any transaction
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_psel)
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= 5000) begin
         $display("FAIL");
         $finish;
      end
   end

   // Shared helpers
   task automatic csr_write(cfg_index_type idx, logic [31:0] value);
      @(posedge clock);
      csr_psel <= 1'b1; csr_pwrite <= 1'b1; csr_penable <= 1'b0;
      csr_paddr <= ADDR_W'(idx) << 2; csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel <= 1'b0; csr_penable <= 1'b0; csr_pwrite <= 1'b0;
      case (idx)
         CFG_MIN_DEPTH:     min_depth_q = value[15:0];
         CFG_MAX_DEPTH:     max_depth_q = value[15:0];
         CFG_LAST_COLUMN:   last_col_q = value[12:0];
         CFG_LAST_ROW:      last_row_q = value[12:0];
         CFG_RECIP_FOCAL_X: rfx_q = value[25:0];
         CFG_CENTER_X:      cx_q = value[23:0];
         CFG_RECIP_FOCAL_Y: rfy_q = value[25:0];
         CFG_CENTER_Y:      cy_q = value[23:0];
         default: ;
      endcase
   endtask

   // Called just after the clock rises; drive at once so no pixel is sent again
   task automatic send_pixel(pixel_type px);
      int gap;
      if (!calm && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         gap = $urandom_range(1, 14);
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {6'd0, px.col, px.row, px.prev_col, px.next_col, px.prev_row,
                    px.next_row, px.center};
      do @(posedge clock); while (!req_tready);
      expected_points = {expected_points, predict_point(px)};
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      while (expected_points.size() != 0) @(posedge clock);
   endtask

   function automatic logic [15:0] near_depth(logic [15:0] c);
      int v = int'(c) + $urandom_range(0, 50) - 25;
      return v < 0 ? 16'd0 : (v > 65535 ? 16'hFFFF : 16'(v));
   endfunction

   function automatic pixel_type random_pixel();
      pixel_type px;
      px.center = $urandom_range(0, 7) == 0 ? 16'($urandom) : 16'($urandom_range(0, 4000));
      if ($urandom_range(0, 5) == 0) begin
         px.next_row = 16'($urandom); px.prev_row = 16'($urandom);
         px.next_col = 16'($urandom); px.prev_col = 16'($urandom);
      end else begin
         px.next_row = near_depth(px.center); px.prev_row = near_depth(px.center);
         px.next_col = near_depth(px.center); px.prev_col = near_depth(px.center);
      end
      if ($urandom_range(0, 4) == 0) begin
         px.row = 13'($urandom); px.col = 13'($urandom);
      end else begin
         px.row = 13'($urandom_range(0, 481)); px.col = 13'($urandom_range(0, 641));
      end
      return px;
   endfunction

   function automatic pixel_type make_pixel(int c, nr, pr, nc, pc, r, col);
      pixel_type px;
      px.center = 16'(c); px.next_row = 16'(nr); px.prev_row = 16'(pr);
      px.next_col = 16'(nc); px.prev_col = 16'(pc); px.row = 13'(r); px.col = 13'(col);
      return px;
   endfunction

   // Tests
   task automatic test_defaults_directed();
      send_pixel(make_pixel(0, 0, 0, 0, 0, 0, 0));
      send_pixel(make_pixel(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8191, 8191));
      send_pixel(make_pixel(1000, 1000, 1000, 1000, 1000, 240, 320));
      send_pixel(make_pixel(1000, 1020, 980, 1020, 980, 100, 100));
      send_pixel(make_pixel(1000, 1021, 979, 1021, 979, 100, 100));
      send_pixel(make_pixel(1000, 980, 1020, 980, 1020, 100, 100));
      send_pixel(make_pixel(1000, 1020, 980, 990, 1010, 0, 5));
      send_pixel(make_pixel(1000, 1020, 980, 990, 1010, 5, 0));
      send_pixel(make_pixel(1000, 1020, 980, 990, 1010, 479, 5));
      send_pixel(make_pixel(1000, 1020, 980, 990, 1010, 5, 639));
      send_pixel(make_pixel(1000, 1020, 980, 990, 1010, 478, 638));
      send_pixel(make_pixel(15, 0, 30, 35, 0, 1, 1));
      send_pixel(make_pixel(16'hFFFF, 16'hFFEB, 0, 16'hFFFF, 16'hFFEA, 0, 8191));
      send_pixel(make_pixel(65535, 65535, 65535, 65535, 65535, 8191, 0));
      send_pixel(make_pixel(1, 0, 0, 0, 0, 8191, 8191));
      send_pixel(make_pixel(20, 0, 40, 41, 0, 2, 2));
      send_pixel(make_pixel(16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA, 13'h0AAA, 13'h1555));
      send_pixel(make_pixel(16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555, 13'h1555, 13'h0AAA));
      drain();
   endtask

   task automatic test_random_pixels(int count);
      for (int i = 0; i < count; i++) send_pixel(random_pixel());
      drain();
   endtask

   task automatic test_narrow_band_wide_image();
      csr_write(CFG_MIN_DEPTH, 500);
      csr_write(CFG_MAX_DEPTH, 2000);
      csr_write(CFG_LAST_COLUMN, 8191);
      csr_write(CFG_LAST_ROW, 8191);
      csr_write(CFG_RECIP_FOCAL_X, 32'h3FFFFFF);
      csr_write(CFG_CENTER_X, 0);
      csr_write(CFG_RECIP_FOCAL_Y, 32'h3FFFFFF);
      csr_write(CFG_CENTER_Y, 0);
      send_pixel(make_pixel(499, 0, 0, 0, 0, 8190, 8190));
      send_pixel(make_pixel(500, 0, 0, 0, 0, 8191, 8191));
      send_pixel(make_pixel(2000, 0, 0, 0, 0, 8190, 1));
      send_pixel(make_pixel(2001, 0, 0, 0, 0, 1, 8190));
      test_random_pixels(300);
   endtask

   task automatic test_inverted_band_far_center();
      csr_write(CFG_MIN_DEPTH, 65535);
      csr_write(CFG_MAX_DEPTH, 0);
      csr_write(CFG_LAST_COLUMN, 0);
      csr_write(CFG_LAST_ROW, 0);
      csr_write(CFG_RECIP_FOCAL_X, 0);
      csr_write(CFG_CENTER_X, 32'hFFFFFF);
      csr_write(CFG_RECIP_FOCAL_Y, 1);
      csr_write(CFG_CENTER_Y, 32'hFFFFFF);
      test_random_pixels(300);
   endtask

   task automatic test_random_settings();
      for (int k = 0; k < 3; k++) begin
         csr_write(CFG_MIN_DEPTH, $urandom_range(0, 1500));
         csr_write(CFG_MAX_DEPTH, $urandom_range(1000, 65535));
         csr_write(CFG_LAST_COLUMN, $urandom_range(1, 700));
         csr_write(CFG_LAST_ROW, $urandom_range(1, 500));
         csr_write(CFG_RECIP_FOCAL_X, $urandom_range(0, 26'h3FFFFFF));
         csr_write(CFG_CENTER_X, $urandom_range(0, 24'hFFFFFF));
         csr_write(CFG_RECIP_FOCAL_Y, $urandom_range(0, 26'h3FFFFFF));
         csr_write(CFG_CENTER_Y, $urandom_range(0, 24'hFFFFFF));
         test_random_pixels(100);
      end
   endtask

   task automatic test_restore_and_pause();
      csr_write(CFG_MIN_DEPTH, 32'(RST_MIN_DEPTH));
      csr_write(CFG_MAX_DEPTH, 32'(RST_MAX_DEPTH));
      csr_write(CFG_LAST_COLUMN, 32'(RST_LAST_COLUMN));
      csr_write(CFG_LAST_ROW, 32'(RST_LAST_ROW));
      csr_write(CFG_RECIP_FOCAL_X, 32'(RST_RECIP_FOCAL_X));
      csr_write(CFG_CENTER_X, 32'(RST_CENTER_X));
      csr_write(CFG_RECIP_FOCAL_Y, 32'(RST_RECIP_FOCAL_Y));
      csr_write(CFG_CENTER_Y, 32'(RST_CENTER_Y));
      // hold the sender until the pipeline has emptied, then resume
      for (int i = 0; i < 4; i++) test_random_pixels(50);
   endtask

   task automatic test_full_rate();
      calm = 1'b1;
      test_random_pixels(230);
   endtask

   initial begin
      min_depth_q = RST_MIN_DEPTH; max_depth_q = RST_MAX_DEPTH;
      last_col_q = RST_LAST_COLUMN; last_row_q = RST_LAST_ROW;
      rfx_q = RST_RECIP_FOCAL_X; cx_q = RST_CENTER_X;
      rfy_q = RST_RECIP_FOCAL_Y; cy_q = RST_CENTER_Y;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      test_defaults_directed();
      test_random_pixels(200);
      test_narrow_band_wide_image();
      test_inverted_band_far_center();
      test_random_settings();
      test_restore_and_pause();
      test_full_rate();
      repeat (100) @(posedge clock);
      if (error_count == 0 && expected_points.size() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end
endmodule
`default_nettype wire

@@ files.f @@
+incdir+sv
sv/dnb_pkg.sv
sv/dnb_delay.sv
sv/dnb_sqrt.sv
sv/dnb_div.sv
sv/depth_normal_and_backprojection.sv
sim/depth_normal_and_backprojection_tb.sv
